// ===== src/qnlerp_pkg.sv =====
// ----------------------------------------------------------------------------
// qnlerp_pkg
// Shared types and constants of the quaternion nlerp pipeline.
// ----------------------------------------------------------------------------
package qnlerp_pkg;

    localparam int COMP_W     = 16;
    localparam int MAG_W      = 31;
    localparam int NMAG_W     = 30;
    localparam int SUM_W      = 62;
    localparam int ROOT_W     = 31;
    localparam int QUOT_W     = 16;
    localparam int REM_W      = 46;

    localparam logic [15:0] WEIGHT_ONE = 16'h8000;
    localparam logic [15:0] COMP_SAT   = 16'h7FFF;

    typedef logic [3:0][COMP_W-1:0] quat_t;

    typedef struct packed {
        logic [3:0][NMAG_W-1:0] mag;
        logic [3:0]             neg;
        logic                   zero;
        logic                   last;
    } side_t;

endpackage

// ===== src/quaternion_nlerp_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_nlerp_unit
// Normalized linear interpolation of quaternion pairs, Q1.15 components.
//
//   channel   dir  payload
//   s_*       in   tdata: prev x,y,z,w, cur x,y,z,w; tlast: batch end
//   m_*       out  tdata: out x,y,z,w; tuser: zero norm; tlast: batch end
//   apb       in   blend_weight at byte address 0
//
// One item per cycle unless the output stalls; pipeline: 3 blend, 4 normalize, 31 square
// root bit steps, 1 divide setup, 16 quotient bit steps, 1 output register.
// The whole pipeline advances when the output register is empty or taken;
// a stall holds every stage in place.
// Reset clears the valid bits and sets blend_weight to 1.0.
// ----------------------------------------------------------------------------
module quaternion_nlerp_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // prev_x, prev_y, prev_z, prev_w, cur_x .. cur_w
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,   // out_x, out_y, out_z, out_w
    output logic          m_tuser,   // zero_norm
    output logic          m_tlast,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import qnlerp_pkg::*;

    localparam logic REG_BLEND_WEIGHT = 1'b0;

    logic [15:0]      weight_reg;
    logic             ce;
    quat_t            prev;
    quat_t            cur;

    logic             b_valid;
    logic [3:0][30:0] b_mag;
    logic [3:0]       b_neg;
    logic             b_last;

    logic             n_valid;
    logic [61:0]      n_sum;
    side_t            n_side;

    logic             r_valid;
    logic [30:0]      r_root;
    side_t            r_side;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BLEND_WEIGHT) ? {16'd0, weight_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_ONE;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_BLEND_WEIGHT))
        begin
            weight_reg <= pwdata[15:0];
        end
    end

    assign ce       = m_tready || !m_tvalid;
    assign s_tready = ce;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prev[i] = s_tdata[i*16 +: 16];
            cur[i]  = s_tdata[64 + i*16 +: 16];
        end
    end

    qnl_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_tvalid && s_tready),
        .prev      (prev),
        .cur       (cur),
        .in_last   (s_tlast),
        .weight    (weight_reg),
        .out_valid (b_valid),
        .mag       (b_mag),
        .neg       (b_neg),
        .out_last  (b_last)
    );

    qnl_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (b_valid),
        .mag       (b_mag),
        .neg       (b_neg),
        .in_last   (b_last),
        .out_valid (n_valid),
        .sum       (n_sum),
        .side      (n_side)
    );

    qnl_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (n_valid),
        .sum       (n_sum),
        .in_side   (n_side),
        .out_valid (r_valid),
        .root      (r_root),
        .out_side  (r_side)
    );

    qnl_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (r_valid),
        .root      (r_root),
        .in_side   (r_side),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_zero  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

// ===== src/qnl_blend.sv =====
// ----------------------------------------------------------------------------
// qnl_blend
// Weighted products, hemisphere test and blend magnitudes (three stages).
// ----------------------------------------------------------------------------
module qnl_blend (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ce,
    input  logic               in_valid,
    input  qnlerp_pkg::quat_t  prev,
    input  qnlerp_pkg::quat_t  cur,
    input  logic               in_last,
    input  logic [15:0]        weight,
    output logic               out_valid,
    output logic [3:0][30:0]   mag,
    output logic [3:0]         neg,
    output logic               out_last
);
    import qnlerp_pkg::*;

    logic [15:0]        w_eff;
    logic [15:0]        w_inv;
    logic [3:0][32:0]   pw_full;
    logic [3:0][32:0]   cw_full;
    logic [3:0][31:0]   pw_next;
    logic [3:0][31:0]   cw_next;
    logic [3:0][31:0]   dt_next;
    logic [3:0][31:0]   pw_reg;
    logic [3:0][31:0]   cw_reg;
    logic [3:0][31:0]   dt_reg;
    logic               v1_reg;
    logic               last1_reg;

    logic [33:0]        dsum;
    logic [3:0][31:0]   pw2_reg;
    logic [3:0][31:0]   cw2_reg;
    logic               flip2_reg;
    logic               v2_reg;
    logic               last2_reg;

    logic [3:0][31:0]   b_next;
    logic [3:0][31:0]   bm_next;
    logic [3:0][30:0]   mag_reg;
    logic [3:0]         neg_reg;
    logic               v3_reg;
    logic               last3_reg;

    assign w_eff = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
    assign w_inv = WEIGHT_ONE - w_eff;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pw_full[i] = $signed(prev[i]) * $signed({1'b0, w_inv});
            cw_full[i] = $signed(cur[i]) * $signed({1'b0, w_eff});
            pw_next[i] = pw_full[i][31:0];
            cw_next[i] = cw_full[i][31:0];
            dt_next[i] = $signed(prev[i]) * $signed(cur[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pw_reg    <= pw_next;
            cw_reg    <= cw_next;
            dt_reg    <= dt_next;
            last1_reg <= in_last;
        end
    end

    assign dsum = {{2{dt_reg[0][31]}}, dt_reg[0]} + {{2{dt_reg[1][31]}}, dt_reg[1]}
                + {{2{dt_reg[2][31]}}, dt_reg[2]} + {{2{dt_reg[3][31]}}, dt_reg[3]};

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pw2_reg   <= pw_reg;
            cw2_reg   <= cw_reg;
            flip2_reg <= dsum[33];
            last2_reg <= last1_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            b_next[i]  = flip2_reg ? (pw2_reg[i] - cw2_reg[i]) : (pw2_reg[i] + cw2_reg[i]);
            bm_next[i] = b_next[i][31] ? (32'd0 - b_next[i]) : b_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 4; i++)
            begin
                mag_reg[i] <= bm_next[i][30:0];
                neg_reg[i] <= b_next[i][31];
            end
            last3_reg <= last2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign mag       = mag_reg;
    assign neg       = neg_reg;
    assign out_last  = last3_reg;

endmodule

// ===== src/qnl_norm.sv =====
// ----------------------------------------------------------------------------
// qnl_norm
// Common normalizing shift of the magnitudes and sum of squares (four stages).
// ----------------------------------------------------------------------------
module qnl_norm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ce,
    input  logic               in_valid,
    input  logic [3:0][30:0]   mag,
    input  logic [3:0]         neg,
    input  logic               in_last,
    output logic               out_valid,
    output logic [61:0]        sum,
    output qnlerp_pkg::side_t  side
);
    import qnlerp_pkg::*;

    logic [30:0]        orv;
    logic [4:0]         left_next;
    logic [3:0][30:0]   mag4_reg;
    logic [3:0]         neg4_reg;
    logic               last4_reg;
    logic               right4_reg;
    logic [4:0]         left4_reg;
    logic               zero4_reg;
    logic               v4_reg;

    logic [3:0][30:0]   shl;
    side_t              side5_next;
    side_t              side5_reg;
    logic               v5_reg;

    logic [3:0][59:0]   sq6_reg;
    side_t              side6_reg;
    logic               v6_reg;

    logic [61:0]        sum7_reg;
    side_t              side7_reg;
    logic               v7_reg;

    assign orv = mag[0] | mag[1] | mag[2] | mag[3];

    always_comb
    begin
        left_next = 5'd0;
        for (int i = 0; i < 30; i++)
        begin
            if (orv[i])
            begin
                left_next = 5'(29 - i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (ce)
        begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            mag4_reg   <= mag;
            neg4_reg   <= neg;
            last4_reg  <= in_last;
            right4_reg <= orv[30];
            left4_reg  <= left_next;
            zero4_reg  <= (orv == 31'd0);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            shl[i] = mag4_reg[i] << left4_reg;
            side5_next.mag[i] = right4_reg ? mag4_reg[i][30:1] : shl[i][29:0];
        end
        side5_next.neg  = neg4_reg;
        side5_next.zero = zero4_reg;
        side5_next.last = last4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            side5_reg <= side5_next;
            for (int i = 0; i < 4; i++)
            begin
                sq6_reg[i] <= side5_reg.mag[i] * side5_reg.mag[i];
            end
            side6_reg <= side5_reg;
            sum7_reg  <= 62'(sq6_reg[0]) + 62'(sq6_reg[1]) + 62'(sq6_reg[2])
                       + 62'(sq6_reg[3]);
            side7_reg <= side6_reg;
        end
    end

    assign out_valid = v7_reg;
    assign sum       = sum7_reg;
    assign side      = side7_reg;

endmodule

// ===== src/qnl_isqrt.sv =====
// ----------------------------------------------------------------------------
// qnl_isqrt
// Floor square root of the sum of squares, one root bit per stage.
// ----------------------------------------------------------------------------
module qnl_isqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ce,
    input  logic               in_valid,
    input  logic [61:0]        sum,
    input  qnlerp_pkg::side_t  in_side,
    output logic               out_valid,
    output logic [30:0]        root,
    output qnlerp_pkg::side_t  out_side
);
    import qnlerp_pkg::*;

    logic [61:0] rem_reg  [ROOT_W];
    logic [30:0] root_reg [ROOT_W];
    side_t       side_reg [ROOT_W];
    logic        v_reg    [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_step
        localparam int K = ROOT_W - 1 - j;
        logic [61:0] rem_in;
        logic [30:0] root_in;
        side_t       side_in;
        logic        v_in;
        logic [62:0] term;
        logic [62:0] diff;
        logic        ge;

        if (j == 0)
        begin : g_first
            assign rem_in  = sum;
            assign root_in = 31'd0;
            assign side_in = in_side;
            assign v_in    = in_valid;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign side_in = side_reg[j-1];
            assign v_in    = v_reg[j-1];
        end

        assign term = (63'(root_in) << (K + 1)) + (63'(1) << (2 * K));
        assign diff = {1'b0, rem_in} - term;
        assign ge   = ({1'b0, rem_in} >= term);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (ce)
            begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[j]  <= ge ? diff[61:0] : rem_in;
                root_reg[j] <= ge ? (root_in | (31'(1) << K)) : root_in;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// ===== src/qnl_divide.sv =====
// ----------------------------------------------------------------------------
// qnl_divide
// Rounded division of each magnitude by the norm, one quotient bit per
// stage, then saturation and sign.
// ----------------------------------------------------------------------------
module qnl_divide (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ce,
    input  logic               in_valid,
    input  logic [30:0]        root,
    input  qnlerp_pkg::side_t  in_side,
    output logic               out_valid,
    output logic [63:0]        out_data,
    output logic               out_zero,
    output logic               out_last
);
    import qnlerp_pkg::*;

    logic [3:0][45:0] r0_reg;
    logic [30:0]      n0_reg;
    logic [3:0]       neg0_reg;
    logic             zero0_reg;
    logic             last0_reg;
    logic             v0_reg;

    logic [3:0][45:0] r_reg    [QUOT_W];
    logic [3:0][15:0] q_reg    [QUOT_W];
    logic [30:0]      n_reg    [QUOT_W];
    logic [3:0]       neg_reg  [QUOT_W];
    logic             zero_reg [QUOT_W];
    logic             last_reg [QUOT_W];
    logic             v_reg    [QUOT_W];

    logic [3:0][15:0] qs;
    logic [63:0]      data_next;
    logic [63:0]      data_reg;
    logic             zout_reg;
    logic             lout_reg;
    logic             vout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else if (ce)
        begin
            v0_reg   <= in_valid;
            vout_reg <= v_reg[QUOT_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 4; i++)
            begin
                r0_reg[i] <= {1'b0, in_side.mag[i], 15'd0} + 46'(root[30:1]);
            end
            n0_reg    <= root;
            neg0_reg  <= in_side.neg;
            zero0_reg <= in_side.zero;
            last0_reg <= in_side.last;
        end
    end

    for (genvar j = 0; j < QUOT_W; j++)
    begin : g_step
        localparam int K = QUOT_W - 1 - j;
        logic [3:0][45:0] r_in;
        logic [3:0][15:0] q_in;
        logic [30:0]      n_in;
        logic [3:0]       neg_in;
        logic             zero_in;
        logic             last_in;
        logic             v_in;
        logic [46:0]      d;
        logic [3:0][46:0] diff;
        logic [3:0]       ge;

        if (j == 0)
        begin : g_first
            assign r_in    = r0_reg;
            assign q_in    = '0;
            assign n_in    = n0_reg;
            assign neg_in  = neg0_reg;
            assign zero_in = zero0_reg;
            assign last_in = last0_reg;
            assign v_in    = v0_reg;
        end
        else
        begin : g_next
            assign r_in    = r_reg[j-1];
            assign q_in    = q_reg[j-1];
            assign n_in    = n_reg[j-1];
            assign neg_in  = neg_reg[j-1];
            assign zero_in = zero_reg[j-1];
            assign last_in = last_reg[j-1];
            assign v_in    = v_reg[j-1];
        end

        assign d = 47'(n_in) << K;

        always_comb
        begin
            for (int i = 0; i < 4; i++)
            begin
                diff[i] = {1'b0, r_in[i]} - d;
                ge[i]   = ({1'b0, r_in[i]} >= d);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (ce)
            begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    r_reg[j][i] <= ge[i] ? diff[i][45:0] : r_in[i];
                    q_reg[j][i] <= ge[i] ? (q_in[i] | (16'(1) << K)) : q_in[i];
                end
                n_reg[j]    <= n_in;
                neg_reg[j]  <= neg_in;
                zero_reg[j] <= zero_in;
                last_reg[j] <= last_in;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            qs[i] = q_reg[QUOT_W-1][i][15] ? COMP_SAT : q_reg[QUOT_W-1][i];
            if (zero_reg[QUOT_W-1])
            begin
                data_next[i*16 +: 16] = 16'd0;
            end
            else
            begin
                data_next[i*16 +: 16] = neg_reg[QUOT_W-1][i] ? (16'd0 - qs[i]) : qs[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            data_reg <= data_next;
            zout_reg <= zero_reg[QUOT_W-1];
            lout_reg <= last_reg[QUOT_W-1];
        end
    end

    assign out_valid = vout_reg;
    assign out_data  = data_reg;
    assign out_zero  = zout_reg;
    assign out_last  = lout_reg;

endmodule

// ===== src/qnl_checker.sv =====
// ----------------------------------------------------------------------------
// qnl_checker
// Port-level checks of the quaternion nlerp unit.
// ----------------------------------------------------------------------------
module qnl_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          s_tready,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [63:0]   m_tdata,
    input logic          m_tuser,
    input logic          m_tlast,
    input logic          pready
);

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == 64'd0))
        else $error("zero norm item with nonzero components");

    a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:0] != 16'h8000 && m_tdata[31:16] != 16'h8000
                   && m_tdata[47:32] != 16'h8000 && m_tdata[63:48] != 16'h8000))
        else $error("output component below saturation range");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && $stable(m_tlast)))
        else $error("stalled output item changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind quaternion_nlerp_unit qnl_checker u_qnl_checker (.*);

// ===== tb/quaternion_nlerp_unit_tb.sv =====
// ----------------------------------------------------------------------------
// quaternion_nlerp_unit_tb
// Streams quaternion pairs through the nlerp unit at several blend weights.
// Each output item is checked against a predictor built from the dot-product
// sign flip, the exact blend, the normalize shift, an integer square root and
// a rounded divide. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module quaternion_nlerp_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import qnlerp_pkg::*;

    localparam int WATCH_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 120;
    localparam logic [2:0] ADDR_WEIGHT = 3'd0;
    localparam logic [2:0] ADDR_UNUSED = 3'd4;

    typedef struct {
        logic [127:0] data;
        logic         last;
        int           gap;
    } pair_item_t;

    typedef struct {
        logic [63:0] quat;
        logic        zero;
        logic        last;
    } blend_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;   // prev_x, prev_y, prev_z, prev_w, cur_x .. cur_w
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;        // out_x, out_y, out_z, out_w
    logic         m_tuser;        // zero_norm
    logic         m_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    pair_item_t    pending_pairs[$];
    blend_result_t expected_blends[$];
    logic [15:0]   weight_shadow = WEIGHT_ONE;
    int            mismatches = 0;
    int            pairs_taken = 0;
    int            send_wait = 0;
    int            recv_wait = 0;
    int            quiet_cycles = 0;
    logic          calm = 1'b0;
    logic          rx_block = 1'b0;

    quaternion_nlerp_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic blend_result_t nlerp_predict(input logic [127:0] d, input logic last,
                                                    input logic [15:0] wgt);
        blend_result_t   res;
        longint          p[4];
        longint          c[4];
        longint          bl[4];
        longint unsigned mag[4];
        logic            neg[4];
        longint          dot;
        longint          w;
        longint unsigned big;
        longint unsigned total;
        longint unsigned root;
        longint unsigned q;
        int              left;
        int              right;
        logic [15:0]     comp;
        dot = 0;
        big = 0;
        total = 0;
        left = 0;
        right = 0;
        w = (wgt > WEIGHT_ONE) ? 32768 : longint'(wgt);
        for (int i = 0; i < 4; i++)
        begin
            p[i] = longint'($signed(d[16*i +: 16]));
            c[i] = longint'($signed(d[64 + 16*i +: 16]));
            dot = dot + p[i] * c[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            if (dot < 0)
                c[i] = -c[i];
            bl[i] = p[i] * (32768 - w) + c[i] * w;
            neg[i] = bl[i] < 0;
            mag[i] = neg[i] ? longint'(-bl[i]) : longint'(bl[i]);
            if (mag[i] > big)
                big = mag[i];
        end
        res.last = last;
        res.quat = '0;
        if (big == 0)
        begin
            res.zero = 1'b1;
            return res;
        end
        while (big >= (64'd1 << 30))
        begin
            big = big >> 1;
            right++;
        end
        while (big < (64'd1 << 29))
        begin
            big = big << 1;
            left++;
        end
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = (mag[i] >> right) << left;
            total = total + mag[i] * mag[i];
        end
        root = int_sqrt(total);
        for (int i = 0; i < 4; i++)
        begin
            q = ((mag[i] << 15) + (root >> 1)) / root;
            if (q > 32767)
                q = 32767;
            comp = q[15:0];
            res.quat[16*i +: 16] = neg[i] ? -comp : comp;
        end
        res.zero = 1'b0;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            weight_shadow <= WEIGHT_ONE;
        else if (psel && penable && pwrite && pready && paddr == ADDR_WEIGHT)
            weight_shadow <= pwdata[15:0];
    end

    always @(posedge clk)
    begin
        logic       nv;
        pair_item_t it;
        nv = s_tvalid;
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_blends.insert(expected_blends.size(),
                                   nlerp_predict(s_tdata, s_tlast, weight_shadow));
            pairs_taken++;
            nv = 1'b0;
        end
        if (rst_n && !nv && pending_pairs.size() > 0)
        begin
            if (send_wait < pending_pairs[0].gap)
            begin
                send_wait++;
            end
            else
            begin
                it = pending_pairs.pop_front();
                send_wait = 0;
                s_tdata <= it.data;
                s_tlast <= it.last;
                nv = 1'b1;
            end
        end
        s_tvalid <= nv;
    end

    always @(posedge clk)
    begin
        logic          nr;
        blend_result_t e;
        nr = m_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_blends.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: data %h zero %b last %b",
                             m_tdata, m_tuser, m_tlast);
            end
            else
            begin
                e = expected_blends.pop_front();
                if (m_tdata !== e.quat || m_tuser !== e.zero || m_tlast !== e.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%b/%b got %h/%b/%b", e.quat, e.zero,
                                 e.last, m_tdata, m_tuser, m_tlast);
                end
            end
            nr = 1'b0;
            recv_wait = calm ? 0 : $urandom_range(0, 9);
        end
        if (!nr && rst_n && !rx_block)
        begin
            if (recv_wait > 0)
                recv_wait--;
            else
                nr = 1'b1;
        end
        if (rx_block)
            nr = 1'b0;
        m_tready <= nr;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("quaternion_nlerp_unit_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        wait (pairs_taken >= 300);
        @(posedge clk);
        rx_block <= 1'b1;
        repeat (300) @(posedge clk);
        rx_block <= 1'b0;
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain_all();
        wait (pending_pairs.size() == 0 && !s_tvalid && expected_blends.size() == 0);
        repeat (64) @(posedge clk);
    endtask

    task automatic push_pair(input logic [15:0] px, py, pz, pw, cx, cy, cz, cw,
                             input logic last);
        pair_item_t it;
        it.data = {cw, cz, cy, cx, pw, pz, py, px};
        it.last = last;
        it.gap = calm ? 0 : $urandom_range(0, 9);
        pending_pairs.insert(pending_pairs.size(), it);
    endtask

    task automatic push_directed();
        push_pair(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                  16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        push_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                  16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
        push_pair(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                  16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
        push_pair(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        push_pair(16'd1000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1000, 16'd0, 16'd0, 1'b0);
        push_pair(16'd12000, 16'd300, 16'hF000, 16'd5, 16'hD120, 16'hFED4, 16'd4096,
                  16'hFFFB, 1'b0);
        push_pair(16'd100, 16'd200, 16'd0, 16'd50, 16'hFF9C, 16'hFF38, 16'd0, 16'hFFCE,
                  1'b1);
        push_pair(16'd0, 16'd0, 16'd0, 16'h4000, 16'd0, 16'd0, 16'd0, 16'h4000, 1'b0);
        push_pair(16'd0, 16'hC000, 16'd0, 16'd0, 16'd0, 16'hC000, 16'd0, 16'd0, 1'b0);
        push_pair(16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 1'b1);
        push_pair(16'hFFFF, 16'd1, 16'hFFFF, 16'd1, 16'd2, 16'd0, 16'd0, 16'd0, 1'b0);
        push_pair(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                  16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b1);
    endtask

    task automatic push_random(input int count);
        logic [15:0] v[8];
        int          kind;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 3);
            for (int i = 0; i < 4; i++)
            begin
                case (kind)
                    0: v[i] = 16'($urandom);
                    1: v[i] = 16'($urandom_range(0, 16)) - 16'd8;
                    2: v[i] = 16'($urandom);
                    default: v[i] = ($urandom_range(0, 7) == 0) ? 16'h0 : 16'($urandom);
                endcase
            end
            for (int i = 0; i < 4; i++)
            begin
                case (kind)
                    0: v[4 + i] = 16'($urandom);
                    1: v[4 + i] = 16'($urandom_range(0, 16)) - 16'd8;
                    2: v[4 + i] = v[i] + 16'($urandom_range(0, 512)) - 16'd256;
                    default: v[4 + i] = ($urandom_range(0, 1) == 0) ? -v[i] : v[i];
                endcase
            end
            push_pair(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7],
                      1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        logic [31:0] weights[7];
        weights = '{32'h8000, 32'h0, 32'h4000, 32'hFFFF, 32'h1, 32'h7FFF, 32'h0};
        weights[6] = $urandom_range(0, 32768);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 7; ph++)
        begin
            calm <= (ph % 3 == 2);
            if (ph > 0)
            begin
                drain_all();
                apb_write(ADDR_WEIGHT, weights[ph]);
                apb_write(ADDR_UNUSED, $urandom);
            end
            @(posedge clk);
            push_directed();
            push_random(140);
        end
        drain_all();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_blends.size() == 0)
            $display("quaternion_nlerp_unit_tb OK");
        else
            $display("quaternion_nlerp_unit_tb NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
src/qnlerp_pkg.sv
src/qnl_blend.sv
src/qnl_norm.sv
src/qnl_isqrt.sv
src/qnl_divide.sv
src/quaternion_nlerp_unit.sv
src/qnl_checker.sv
tb/quaternion_nlerp_unit_tb.sv
